>>> src/mctt_pkg.sv
// Types and constants shared by the tick timer bank.
// No dependencies.
package mctt_pkg;

  localparam int unsigned ModeBits   = 4;
  localparam int unsigned ChanBits   = 3;
  localparam int unsigned PeriodBits = 32;
  localparam int unsigned MaskBits   = 8;

  // Command codes carried on the input tuser
  localparam logic [ModeBits-1:0] CmdTick      = 4'd0;
  localparam logic [ModeBits-1:0] CmdInit      = 4'd1;
  localparam logic [ModeBits-1:0] CmdStart     = 4'd2;
  localparam logic [ModeBits-1:0] CmdStop      = 4'd3;
  localparam logic [ModeBits-1:0] CmdReset     = 4'd4;
  localparam logic [ModeBits-1:0] CmdSetPeriod = 4'd5;
  localparam logic [ModeBits-1:0] CmdSetMode   = 4'd6;
  localparam logic [ModeBits-1:0] CmdSetNotify = 4'd7;
  localparam logic [ModeBits-1:0] CmdQuery     = 4'd8;

  typedef struct packed {
    logic [ModeBits-1:0]   mode;
    logic [ChanBits-1:0]   channel;
    logic [PeriodBits-1:0] period_value;
    logic                  one_shot;
    logic                  notify_enable;
  } cmd_t;

  // Per-channel status after the step
  typedef struct packed {
    logic                  fire;
    logic                  run;
    logic [PeriodBits-1:0] remaining;
  } chan_stat_t;

endpackage

>>> src/mctt_channel.sv
// One timer channel: its state registers, command decode and tick update.
// Depends on mctt_pkg.
module mctt_channel #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,   // a command leaves the input stage this cycle
  input  logic                sel_i,    // command addresses this channel
  input  mctt_pkg::cmd_t      cmd_i,
  output mctt_pkg::chan_stat_t stat_o
);

  localparam int unsigned CmpBits = (COUNT_BITS > mctt_pkg::PeriodBits) ?
                                    COUNT_BITS : mctt_pkg::PeriodBits;

  logic                              run_q, run_d;
  logic                              fired_q, fired_d;
  logic                              os_q, os_d;
  logic                              ntf_q, ntf_d;
  logic [COUNT_BITS-1:0]             cnt_q, cnt_d;
  logic [mctt_pkg::PeriodBits-1:0]   per_q, per_d;

  logic                  active;
  logic                  hit;
  logic                  fire;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [CmpBits-1:0]    cnt_ext;

  assign active  = run_q && !(os_q && fired_q);
  assign cnt_inc = cnt_q + COUNT_BITS'(1);
  assign hit     = CmpBits'(cnt_inc) >= CmpBits'(per_q);

  always_comb begin
    run_d   = run_q;
    fired_d = fired_q;
    os_d    = os_q;
    ntf_d   = ntf_q;
    cnt_d   = cnt_q;
    per_d   = per_q;
    fire    = 1'b0;
    if (step_i) begin
      if (cmd_i.mode == mctt_pkg::CmdTick) begin
        if (active) begin
          cnt_d = cnt_inc;
          if (hit) begin
            fire = ntf_q;
            if (os_q) begin
              fired_d = 1'b1;
              run_d   = 1'b0;
            end else begin
              cnt_d = '0;
            end
          end
        end
      end else if (sel_i) begin
        case (cmd_i.mode)
          mctt_pkg::CmdInit: begin
            per_d   = cmd_i.period_value;
            os_d    = cmd_i.one_shot;
            ntf_d   = cmd_i.notify_enable;
            run_d   = 1'b0;
            fired_d = 1'b0;
            cnt_d   = '0;
          end
          mctt_pkg::CmdStart: begin
            run_d   = 1'b1;
            fired_d = 1'b0;
            cnt_d   = '0;
          end
          mctt_pkg::CmdStop: begin
            run_d = 1'b0;
          end
          mctt_pkg::CmdReset: begin
            fired_d = 1'b0;
            cnt_d   = '0;
          end
          mctt_pkg::CmdSetPeriod: begin
            per_d = cmd_i.period_value;
            cnt_d = '0;
          end
          mctt_pkg::CmdSetMode: begin
            os_d = cmd_i.one_shot;
          end
          mctt_pkg::CmdSetNotify: begin
            ntf_d = cmd_i.notify_enable;
          end
          default: begin
            // query and unused codes leave the channel alone
          end
        endcase
      end
    end
  end

  // status reflects the state after this step
  assign cnt_ext          = CmpBits'(cnt_d);
  assign stat_o.fire      = fire;
  assign stat_o.run       = run_d;
  assign stat_o.remaining = run_d ? (per_d - cnt_ext[mctt_pkg::PeriodBits-1:0]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      fired_q <= 1'b0;
      os_q    <= 1'b0;
      ntf_q   <= 1'b0;
      cnt_q   <= '0;
      per_q   <= '0;
    end else begin
      run_q   <= run_d;
      fired_q <= fired_d;
      os_q    <= os_d;
      ntf_q   <= ntf_d;
      cnt_q   <= cnt_d;
      per_q   <= per_d;
    end
  end

endmodule

>>> src/multi_channel_tick_timer_bank.sv
// Bank of tick timers: input register, per-channel update, result register.
// The result is registered; a command leaves the input register only when the result register is empty or read.
// Throughput: one command per cycle while the output is taken; all channels update in parallel.
// Reset (rst_ni low, async): every channel cleared, both stages empty.
// Depends on mctt_pkg and mctt_channel.
module multi_channel_tick_timer_bank #(
  parameter int unsigned TIMER_COUNT = 8,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] channel, [34:3] period_value, [35] one_shot, [36] notify_enable
  input  logic [39:0] s_axis_tdata,
  // [3:0] mode
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] fired_mask, [8] enabled_flag, [40:9] remaining
  output logic [47:0] m_axis_tdata
);

  localparam int unsigned PB = mctt_pkg::PeriodBits;
  localparam int unsigned CB = mctt_pkg::ChanBits;

  logic            in_vld_q, in_vld_d;
  mctt_pkg::cmd_t  in_q;
  logic            out_vld_q, out_vld_d;
  logic [47:0]     out_q, out_d;

  logic advance;
  logic step;
  logic take;

  mctt_pkg::chan_stat_t    stat [TIMER_COUNT];
  logic [TIMER_COUNT-1:0]  sel;
  logic [mctt_pkg::MaskBits-1:0] fired_mask;
  logic                    enabled_flag;
  logic [PB-1:0]           remaining;

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign step          = in_vld_q && advance;

  for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_chan
    assign sel[i] = (32'(in_q.channel) == i);

    mctt_channel #(
      .COUNT_BITS(COUNT_BITS)
    ) u_chan (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .step_i(step),
      .sel_i (sel[i]),
      .cmd_i (in_q),
      .stat_o(stat[i])
    );
  end

  // only the first eight channels have a mask bit
  for (genvar b = 0; b < mctt_pkg::MaskBits; b++) begin : g_mask
    if (b < TIMER_COUNT) begin : g_on
      assign fired_mask[b] = stat[b].fire;
    end else begin : g_off
      assign fired_mask[b] = 1'b0;
    end
  end

  // addressed channel status; an absent channel matches no select and reads 0
  always_comb begin
    enabled_flag = 1'b0;
    remaining    = '0;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      enabled_flag = enabled_flag | (sel[i] & stat[i].run);
      remaining    = remaining | ({PB{sel[i]}} & stat[i].remaining);
    end
  end

  always_comb begin
    in_vld_d  = take ? 1'b1 : (advance ? 1'b0 : in_vld_q);
    out_vld_d = advance ? in_vld_q : out_vld_q;
    out_d     = {7'b0, remaining, enabled_flag, fired_mask};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q.mode          <= s_axis_tuser;
      in_q.channel       <= s_axis_tdata[CB-1:0];
      in_q.period_value  <= s_axis_tdata[CB+PB-1:CB];
      in_q.one_shot      <= s_axis_tdata[CB+PB];
      in_q.notify_enable <= s_axis_tdata[CB+PB+1];
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

>>> dv/testbench.sv
// Self-checking bench for multi_channel_tick_timer_bank: directed and random
// command streams, a command-level model of the timer bank and a result checker.
// Depends on mctt_pkg and the RTL of the timer bank.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned NumTimers     = 8;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned MaxReports    = 40;

  // unused command codes, handled by the bank like a query
  localparam logic [mctt_pkg::ModeBits-1:0] CmdSpareFirst = mctt_pkg::CmdQuery + 4'd1;
  localparam logic [mctt_pkg::ModeBits-1:0] CmdSpareLast  = 4'd15;

  typedef struct packed {
    logic [mctt_pkg::MaskBits-1:0]   fired;
    logic                            run;
    logic [mctt_pkg::PeriodBits-1:0] remaining;
  } bank_resp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  // model of the timer bank
  logic                            tmr_run     [NumTimers];
  logic                            tmr_done    [NumTimers];
  logic [31:0]                     tmr_cnt     [NumTimers];
  logic [mctt_pkg::PeriodBits-1:0] tmr_period  [NumTimers];
  logic                            tmr_oneshot [NumTimers];
  logic                            tmr_notify  [NumTimers];

  bank_resp_t  resp_q[$];
  int unsigned err_cnt;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  bit          tx_gaps;
  bit          rx_hold_req;

  multi_channel_tick_timer_bank u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic void clear_bank();
    for (int i = 0; i < NumTimers; i++) begin
      tmr_run[i]     = 1'b0;
      tmr_done[i]    = 1'b0;
      tmr_cnt[i]     = '0;
      tmr_period[i]  = '0;
      tmr_oneshot[i] = 1'b0;
      tmr_notify[i]  = 1'b0;
    end
  endfunction

  // Applies one command to the model and returns the status it reports.
  function automatic bank_resp_t apply_cmd(mctt_pkg::cmd_t c);
    bank_resp_t  r;
    int unsigned ch;
    logic        ch_ok;
    r     = '0;
    ch    = 32'(c.channel);
    ch_ok = (ch < NumTimers);
    if (c.mode == mctt_pkg::CmdTick) begin
      for (int i = 0; i < NumTimers; i++) begin
        if (tmr_run[i] && !(tmr_oneshot[i] && tmr_done[i])) begin
          tmr_cnt[i] = tmr_cnt[i] + 32'd1;
          if (tmr_cnt[i] >= tmr_period[i]) begin
            if (tmr_notify[i] && i < mctt_pkg::MaskBits) r.fired[i] = 1'b1;
            if (tmr_oneshot[i]) begin
              tmr_done[i] = 1'b1;
              tmr_run[i]  = 1'b0;
            end else begin
              tmr_cnt[i] = '0;
            end
          end
        end
      end
    end else if (ch_ok) begin
      case (c.mode)
        mctt_pkg::CmdInit: begin
          tmr_period[ch]  = c.period_value;
          tmr_oneshot[ch] = c.one_shot;
          tmr_notify[ch]  = c.notify_enable;
          tmr_run[ch]     = 1'b0;
          tmr_done[ch]    = 1'b0;
          tmr_cnt[ch]     = '0;
        end
        mctt_pkg::CmdStart: begin
          tmr_run[ch]  = 1'b1;
          tmr_cnt[ch]  = '0;
          tmr_done[ch] = 1'b0;
        end
        mctt_pkg::CmdStop: tmr_run[ch] = 1'b0;
        mctt_pkg::CmdReset: begin
          tmr_cnt[ch]  = '0;
          tmr_done[ch] = 1'b0;
        end
        mctt_pkg::CmdSetPeriod: begin
          tmr_period[ch] = c.period_value;
          tmr_cnt[ch]    = '0;
        end
        mctt_pkg::CmdSetMode:   tmr_oneshot[ch] = c.one_shot;
        mctt_pkg::CmdSetNotify: tmr_notify[ch] = c.notify_enable;
        default: ;
      endcase
    end
    if (ch_ok && tmr_run[ch]) begin
      r.run       = 1'b1;
      r.remaining = tmr_period[ch] - tmr_cnt[ch];
    end
    return r;
  endfunction

  // Predicts on every input transfer, checks every output transfer, and
  // ends the run if the bank stops moving.
  always @(posedge clk_i) begin : monitor
    mctt_pkg::cmd_t c;
    bank_resp_t     want;
    bank_resp_t     got;
    logic           moved;
    moved = 1'b0;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      c.mode          = s_axis_tuser;
      c.channel       = s_axis_tdata[2:0];
      c.period_value  = s_axis_tdata[34:3];
      c.one_shot      = s_axis_tdata[35];
      c.notify_enable = s_axis_tdata[36];
      resp_q.push_back(apply_cmd(c));
      moved = 1'b1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      moved     = 1'b1;
      got.fired = m_axis_tdata[7:0];
      got.run   = m_axis_tdata[8];
      got.remaining = m_axis_tdata[40:9];
      if (resp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports)
          $display("%0t: unexpected result, expected none, got %h", $time, got);
      end else begin
        want = resp_q.pop_front();
        if (got.fired !== want.fired) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t: fired_mask expected %h got %h", $time, want.fired, got.fired);
        end
        if (got.run !== want.run) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t: enabled_flag expected %b got %b", $time, want.run, got.run);
        end
        if (got.remaining !== want.remaining) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t: remaining expected %h got %h", $time, want.remaining,
                     got.remaining);
        end
      end
    end
    if (moved) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: repeating ready patterns, plus a long hold-off on request.
  initial begin : rx_side
    logic [31:0] pat;
    int unsigned pat_len;
    int unsigned pat_pos;
    int unsigned pat_left;
    int unsigned hold_left;
    m_axis_tready = 1'b0;
    pat       = '1;
    pat_len   = 1;
    pat_pos   = 0;
    pat_left  = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HoldCycles;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        if (pat_left == 0) begin
          pat_left = $urandom_range(16, 200);
          pat_len  = $urandom_range(1, 32);
          pat_pos  = 0;
          case ($urandom_range(0, 3))
            0:       pat = '1;
            1:       pat = $urandom() | $urandom();
            2:       pat = $urandom();
            default: pat = $urandom() & $urandom();
          endcase
          pat[0] = 1'b1;
        end
        m_axis_tready <= pat[pat_pos];
        pat_pos = (pat_pos + 1) % pat_len;
        pat_left--;
      end
    end
  end

  // One command transfer; bursts of back-to-back items with random gaps when tx_gaps is set.
  task automatic send_cmd(mctt_pkg::cmd_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = tx_gaps ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.mode;
    s_axis_tdata  <= {3'b000, c.notify_enable, c.one_shot, c.period_value, c.channel};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  function automatic mctt_pkg::cmd_t mk_cmd(logic [mctt_pkg::ModeBits-1:0] m,
                                            logic [mctt_pkg::ChanBits-1:0] ch,
                                            logic [mctt_pkg::PeriodBits-1:0] per,
                                            logic os, logic nt);
    mctt_pkg::cmd_t c;
    c.mode          = m;
    c.channel       = ch;
    c.period_value  = per;
    c.one_shot      = os;
    c.notify_enable = nt;
    return c;
  endfunction

  // Mostly short periods so that channels actually expire.
  function automatic logic [mctt_pkg::PeriodBits-1:0] rand_period();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(0, 8);
    else if (sel < 90) return $urandom_range(9, 300);
    else return $urandom();
  endfunction

  function automatic mctt_pkg::cmd_t rand_cmd();
    mctt_pkg::cmd_t c;
    int unsigned    sel;
    sel = $urandom_range(0, 99);
    c = mk_cmd(mctt_pkg::CmdQuery, 3'($urandom()), rand_period(), 1'($urandom()),
               1'($urandom()));
    if (sel < 40)      c.mode = mctt_pkg::CmdTick;
    else if (sel < 50) c.mode = mctt_pkg::CmdInit;
    else if (sel < 58) c.mode = mctt_pkg::CmdStart;
    else if (sel < 63) c.mode = mctt_pkg::CmdStop;
    else if (sel < 68) c.mode = mctt_pkg::CmdReset;
    else if (sel < 76) c.mode = mctt_pkg::CmdSetPeriod;
    else if (sel < 82) c.mode = mctt_pkg::CmdSetMode;
    else if (sel < 88) c.mode = mctt_pkg::CmdSetNotify;
    else if (sel < 94) c.mode = mctt_pkg::CmdQuery;
    else               c.mode = 4'($urandom_range(CmdSpareFirst, CmdSpareLast));
    return c;
  endfunction

  task automatic test_directed();
    send_cmd(mk_cmd(mctt_pkg::CmdQuery, 3'd0, $urandom(), 1'b0, 1'b0));
    // periodic, period 3, notify on
    send_cmd(mk_cmd(mctt_pkg::CmdInit, 3'd0, 32'd3, 1'b0, 1'b1));
    send_cmd(mk_cmd(mctt_pkg::CmdStart, 3'd0, $urandom(), 1'b1, 1'b0));
    repeat (3) send_cmd(mk_cmd(mctt_pkg::CmdTick, 3'd0, $urandom(), 1'($urandom()),
                               1'($urandom())));
    // one-shot, period 1, highest channel
    send_cmd(mk_cmd(mctt_pkg::CmdInit, 3'd7, 32'd1, 1'b1, 1'b1));
    send_cmd(mk_cmd(mctt_pkg::CmdStart, 3'd7, $urandom(), 1'b0, 1'b1));
    repeat (2) send_cmd(mk_cmd(mctt_pkg::CmdTick, 3'd7, $urandom(), 1'($urandom()),
                               1'($urandom())));
    // zero period fires on every tick
    send_cmd(mk_cmd(mctt_pkg::CmdInit, 3'd2, 32'd0, 1'b0, 1'b1));
    send_cmd(mk_cmd(mctt_pkg::CmdStart, 3'd2, '0, 1'b0, 1'b0));
    send_cmd(mk_cmd(mctt_pkg::CmdTick, 3'd2, '1, 1'b1, 1'b1));
    // largest period
    send_cmd(mk_cmd(mctt_pkg::CmdInit, 3'd1, '1, 1'b1, 1'b0));
    send_cmd(mk_cmd(mctt_pkg::CmdStart, 3'd1, '1, 1'b1, 1'b1));
    send_cmd(mk_cmd(mctt_pkg::CmdTick, 3'd1, '0, 1'b0, 1'b0));
    send_cmd(mk_cmd(mctt_pkg::CmdSetPeriod, 3'd1, 32'h5a5a_a5a5, 1'b1, 1'b1));
    send_cmd(mk_cmd(mctt_pkg::CmdSetMode, 3'd2, $urandom(), 1'b1, 1'b0));
    send_cmd(mk_cmd(mctt_pkg::CmdSetNotify, 3'd0, $urandom(), 1'b1, 1'b0));
    send_cmd(mk_cmd(mctt_pkg::CmdTick, 3'd2, $urandom(), 1'($urandom()),
                    1'($urandom())));
    send_cmd(mk_cmd(mctt_pkg::CmdReset, 3'd7, $urandom(), 1'b0, 1'b0));
    send_cmd(mk_cmd(mctt_pkg::CmdStop, 3'd0, $urandom(), 1'b0, 1'b0));
    send_cmd(mk_cmd(CmdSpareLast, 3'd1, $urandom(), 1'b1, 1'b1));
    send_cmd(mk_cmd(CmdSpareFirst, 3'd4, $urandom(), 1'b0, 1'b1));
    send_cmd(mk_cmd(mctt_pkg::CmdQuery, 3'd3, $urandom(), 1'b0, 1'b0));
    send_cmd(mk_cmd(mctt_pkg::CmdTick, 3'd5, $urandom(), 1'($urandom()),
                    1'($urandom())));
  endtask

  task automatic test_random(int unsigned n, bit gaps);
    tx_gaps = gaps;
    repeat (n) send_cmd(rand_cmd());
  endtask

  // Receiver holds off while commands keep coming, so the input stalls.
  task automatic test_backpressure();
    tx_gaps     = 1'b0;
    rx_hold_req = 1'b1;
    repeat (60) send_cmd(rand_cmd());
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = mctt_pkg::CmdTick;
    err_cnt       = 0;
    quiet_cycles  = 0;
    burst_left    = 0;
    tx_gaps       = 1'b1;
    rx_hold_req   = 1'b0;
    clear_bank();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(400, 1'b1);
    test_random(400, 1'b0);
    test_backpressure();
    test_random(400, 1'b1);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
